/* sv/lzc_pkg.sv */
package lzc_pkg;

  // store size and derived widths
  localparam int MAX_RUN = 1024;
  localparam int ADDR_W  = $clog2(MAX_RUN);
  localparam int CNT_W   = ADDR_W + 1;
  localparam int WLK_W   = CNT_W + 1;
  localparam int SUM_W   = WLK_W + 1;

  // word field widths
  localparam int IVL_W  = 12;
  localparam int MEAN_W = 16;
  localparam int CX_W   = 11;
  localparam int ST_W   = 2;

  // status codes
  localparam logic [ST_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [ST_W-1:0] STATUS_SHORT = 2'd1;
  localparam logic [ST_W-1:0] STATUS_OVF   = 2'd2;

  // symbol queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef struct packed {
    logic sym;
    logic last;
  } sym_t;

endpackage

/* sv/lzc_in_if.sv */
interface lzc_in_if;
  logic                      valid;
  logic                      ready;
  logic [lzc_pkg::IVL_W-1:0] interval;
  logic                      last;

  modport source (output valid, output interval, output last, input ready);
  modport sink   (input valid, input interval, input last, output ready);
endinterface

/* sv/lzc_out_if.sv */
interface lzc_out_if;
  logic                     valid;
  logic                     ready;
  logic [lzc_pkg::CX_W-1:0] complexity;
  logic [lzc_pkg::ST_W-1:0] status;

  modport source (output valid, output complexity, output status, input ready);
  modport sink   (input valid, input complexity, input status, output ready);
endinterface

/* sv/lzc_front.sv */
module lzc_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [lzc_pkg::MEAN_W-1:0] cfg_wdata,
  lzc_in_if.sink                     in_ch,
  output logic                       push_valid,
  input  logic                       push_ready,
  output lzc_pkg::sym_t              push_data
);

  logic [lzc_pkg::MEAN_W-1:0] mean_r;
  logic [lzc_pkg::MEAN_W-1:0] scaled;
  logic [lzc_pkg::MEAN_W-1:0] diff;
  logic [lzc_pkg::MEAN_W+4:0] lhs;
  logic [lzc_pkg::MEAN_W+4:0] rhs;

  // mean register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r <= '0;
    end else if (cfg_we) begin
      mean_r <= cfg_wdata;
    end
  end

  // symbol rule: 20 * |16*i - m| > 3 * m
  always_comb begin
    scaled = {in_ch.interval, 4'b0000};
    diff   = (scaled >= mean_r) ? (scaled - mean_r) : (mean_r - scaled);
    lhs    = {1'b0, diff, 4'b0000} + {3'b000, diff, 2'b00};
    rhs    = {4'b0000, mean_r, 1'b0} + {5'b00000, mean_r};
  end

  // hand the classified word to the queue
  assign push_valid     = in_ch.valid;
  assign in_ch.ready    = push_ready;
  assign push_data.sym  = (lhs > rhs);
  assign push_data.last = in_ch.last;

endmodule

/* sv/lzc_queue.sv */
module lzc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  lzc_pkg::sym_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output lzc_pkg::sym_t pop_data
);

  lzc_pkg::sym_t               slot_r [lzc_pkg::QDEPTH];
  logic [lzc_pkg::QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [lzc_pkg::QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [lzc_pkg::QPTR_W:0]    cnt_r, cnt_nxt;
  logic                        do_push, do_pop;

  assign push_ready = (cnt_r != (lzc_pkg::QPTR_W+1)'(lzc_pkg::QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* sv/lzc_back.sv */
module lzc_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  lzc_pkg::sym_t pop_data,
  lzc_out_if.source     out_ch
);

  typedef enum logic [3:0] {
    S_LOAD = 4'b0001,
    S_RD   = 4'b0010,
    S_CMP  = 4'b0100,
    S_DONE = 4'b1000
  } back_state_t;

  back_state_t                state_r, state_nxt;
  logic                       sym_mem [lzc_pkg::MAX_RUN];
  logic                       rd_a_r, rd_b_r;
  logic [lzc_pkg::CNT_W-1:0]  run_len_r, run_len_nxt;
  logic                       ovf_r, ovf_nxt;
  logic [lzc_pkg::WLK_W-1:0]  i_r, i_nxt, k_r, k_nxt, l_r, l_nxt, kmax_r, kmax_nxt;
  logic [lzc_pkg::CNT_W-1:0]  n_r, n_nxt;
  logic [lzc_pkg::CX_W-1:0]   c_r, c_nxt, c_inc;
  logic [lzc_pkg::CX_W-1:0]   res_cx_r, res_cx_nxt;
  logic [lzc_pkg::ST_W-1:0]   res_st_r, res_st_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [lzc_pkg::CX_W-1:0]   out_cx_r, out_cx_nxt;
  logic [lzc_pkg::ST_W-1:0]   out_st_r, out_st_nxt;
  logic                       do_pop, store_ok, wr_en;
  logic [lzc_pkg::CNT_W-1:0]  len_after;
  logic [lzc_pkg::WLK_W-1:0]  sum_a, sum_b, i_inc, k_inc, kmax_new, l_new;
  logic [lzc_pkg::SUM_W-1:0]  match_end, n_ext;
  logic [lzc_pkg::ADDR_W-1:0] addr_a, addr_b;

  assign pop_ready = (state_r == S_LOAD);
  assign do_pop    = pop_valid && pop_ready;
  assign store_ok  = (run_len_r < lzc_pkg::CNT_W'(lzc_pkg::MAX_RUN));
  assign wr_en     = do_pop && store_ok;
  assign len_after = store_ok ? run_len_r + 1'b1 : run_len_r;

  // walk arithmetic
  assign sum_a     = i_r + k_r - 1'b1;
  assign sum_b     = l_r + k_r - 1'b1;
  assign addr_a    = sum_a[lzc_pkg::ADDR_W-1:0];
  assign addr_b    = sum_b[lzc_pkg::ADDR_W-1:0];
  assign i_inc     = i_r + 1'b1;
  assign k_inc     = k_r + 1'b1;
  assign kmax_new  = (k_r > kmax_r) ? k_r : kmax_r;
  assign l_new     = l_r + kmax_new;
  assign n_ext     = lzc_pkg::SUM_W'(n_r);
  assign match_end = lzc_pkg::SUM_W'(l_r) + lzc_pkg::SUM_W'(k_inc) + 1'b1;
  assign c_inc     = (&c_r) ? c_r : c_r + 1'b1;

  // symbol store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      sym_mem[run_len_r[lzc_pkg::ADDR_W-1:0]] <= pop_data.sym;
    end
    if (state_r == S_RD) begin
      rd_a_r <= sym_mem[addr_a];
      rd_b_r <= sym_mem[addr_b];
    end
  end

  // run bookkeeping and phrase walk
  always_comb begin
    state_nxt     = state_r;
    run_len_nxt   = run_len_r;
    ovf_nxt       = ovf_r;
    i_nxt         = i_r;
    k_nxt         = k_r;
    l_nxt         = l_r;
    kmax_nxt      = kmax_r;
    n_nxt         = n_r;
    c_nxt         = c_r;
    res_cx_nxt    = res_cx_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_cx_nxt    = out_cx_r;
    out_st_nxt    = out_st_r;
    case (state_r)
      S_LOAD: begin
        if (do_pop) begin
          run_len_nxt = len_after;
          ovf_nxt     = ovf_r || !store_ok;
          if (pop_data.last) begin
            run_len_nxt = '0;
            ovf_nxt     = 1'b0;
            res_cx_nxt  = '0;
            if (ovf_r || !store_ok) begin
              res_st_nxt = lzc_pkg::STATUS_OVF;
              state_nxt  = S_DONE;
            end else if (len_after < lzc_pkg::CNT_W'(2)) begin
              res_st_nxt = lzc_pkg::STATUS_SHORT;
              state_nxt  = S_DONE;
            end else begin
              res_st_nxt = lzc_pkg::STATUS_OK;
              i_nxt      = '0;
              k_nxt      = lzc_pkg::WLK_W'(1);
              l_nxt      = lzc_pkg::WLK_W'(1);
              kmax_nxt   = lzc_pkg::WLK_W'(1);
              c_nxt      = lzc_pkg::CX_W'(1);
              n_nxt      = len_after - 1'b1;
              state_nxt  = S_RD;
            end
          end
        end
      end
      S_RD: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        state_nxt = S_RD;
        if (rd_a_r == rd_b_r) begin
          // match: extend current phrase
          k_nxt = k_inc;
          if (match_end >= n_ext) begin
            res_cx_nxt = c_inc;
            state_nxt  = S_DONE;
          end
        end else begin
          kmax_nxt = kmax_new;
          i_nxt    = i_inc;
          k_nxt    = lzc_pkg::WLK_W'(1);
          if (i_inc == l_r) begin
            // new phrase
            c_nxt = c_inc;
            l_nxt = l_new;
            if (lzc_pkg::SUM_W'(l_new) + 1'b1 > n_ext) begin
              res_cx_nxt = c_inc;
              state_nxt  = S_DONE;
            end else begin
              i_nxt    = '0;
              kmax_nxt = lzc_pkg::WLK_W'(1);
            end
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_cx_nxt    = res_cx_r;
          out_st_nxt    = res_st_r;
          state_nxt     = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      run_len_r   <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      run_len_r   <= run_len_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // walk and result payload
  always_ff @(posedge clk) begin
    i_r      <= i_nxt;
    k_r      <= k_nxt;
    l_r      <= l_nxt;
    kmax_r   <= kmax_nxt;
    n_r      <= n_nxt;
    c_r      <= c_nxt;
    res_cx_r <= res_cx_nxt;
    res_st_r <= res_st_nxt;
    out_cx_r <= out_cx_nxt;
    out_st_r <= out_st_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.complexity = out_cx_r;
  assign out_ch.status     = out_st_r;

endmodule

/* sv/lempel_ziv_complexity_engine.sv */
// channel   | dir | word fields                 | handshake
// ----------+-----+-----------------------------+------------------------
// in_ch     | in  | interval[11:0], last        | valid / ready
// out_ch    | out | complexity[10:0], status[1:0] | valid / ready
// cfg       | in  | cfg_wdata[15:0] (mean, q4)  | cfg_we, no back-pressure
//
// intervals are classified and queued one per cycle while the queue has room; the back end
// stores one a cycle while loading; after the last word each walk step is a two-port store
// read, then a compare; the done state hands over the result; steps grow with run length
// rst_n is synchronous; the symbol store has no clearing pass, runs only read what they wrote
// in_ch stalls only when the four-word queue fills: during a walk, or when a finished
// result waits behind an unread one; a single unread result does not block loading
module lempel_ziv_complexity_engine (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [lzc_pkg::MEAN_W-1:0] cfg_wdata,
  lzc_in_if.sink                     in_ch,
  lzc_out_if.source                  out_ch
);

  logic          push_valid, push_ready, pop_valid, pop_ready;
  lzc_pkg::sym_t push_data, pop_data;

  lzc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data)
  );

  lzc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  lzc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_data (pop_data),
    .out_ch   (out_ch)
  );

endmodule

/* test/lz_complexity_checker.sv */
`timescale 1ns / 100ps
module lz_complexity_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [lzc_pkg::MEAN_W-1:0] cfg_wdata,
  lzc_in_if                          in_mon,
  lzc_out_if                         out_mon,
  output int unsigned                mismatches,
  output int unsigned                results_due
);

  localparam int unsigned CX_MAX = (1 << lzc_pkg::CX_W) - 1;

  typedef struct packed {
    logic [lzc_pkg::CX_W-1:0] complexity;
    logic [lzc_pkg::ST_W-1:0] status;
  } lz_result_t;

  // predicted copy of the block state
  logic                       sym_store [lzc_pkg::MAX_RUN];
  int unsigned                run_len;
  logic                       run_overflowed;
  logic [lzc_pkg::MEAN_W-1:0] mean_q4;
  lz_result_t                 due_results [$];

  // 1 when the interval strays more than 15 percent from the mean, in integers
  function automatic logic classify(input logic [lzc_pkg::IVL_W-1:0]  ivl,
                                    input logic [lzc_pkg::MEAN_W-1:0] m);
    int unsigned scaled, dev;
    scaled = ivl * 16;
    dev = (scaled >= m) ? scaled - m : m - scaled;
    return (20 * dev > 3 * m);
  endfunction

  function automatic logic sym_at(input int unsigned idx);
    return (idx < lzc_pkg::MAX_RUN) ? sym_store[idx] : 1'b0;
  endfunction

  // lz76 phrase walk with the block's own end bounds, n = len - 1
  function automatic int unsigned lz76_phrase_count(input int unsigned len);
    int unsigned i, k, l, kmax, n, c;
    logic done;
    i = 0;
    k = 1;
    l = 1;
    kmax = 1;
    n = len - 1;
    c = 1;
    done = 1'b0;
    while (!done) begin
      if (sym_at(i + k - 1) == sym_at(l + k - 1)) begin
        k++;
        if (l + k + 1 >= n) begin
          c++;
          done = 1'b1;
        end
      end else begin
        if (k > kmax) kmax = k;
        i++;
        if (i == l) begin
          c++;
          l += kmax;
          if (l + 1 > n) begin
            done = 1'b1;
          end else begin
            i = 0;
            k = 1;
            kmax = 1;
          end
        end else begin
          k = 1;
        end
      end
    end
    return c;
  endfunction

  always @(posedge clk) begin : watch
    lz_result_t  want, got;
    int unsigned cx;
    if (!rst_n) begin
      run_len = 0;
      run_overflowed = 1'b0;
      mean_q4 = '0;
      mismatches = 0;
      due_results.delete();
    end else begin
      // mean register write
      if (cfg_we) mean_q4 = cfg_wdata;

      // accepted interval word
      if (in_mon.valid && in_mon.ready) begin
        if (run_len < lzc_pkg::MAX_RUN) begin
          sym_store[run_len] = classify(in_mon.interval, mean_q4);
          run_len++;
        end else begin
          run_overflowed = 1'b1;
        end
        if (in_mon.last) begin
          want.complexity = '0;
          if (run_overflowed) begin
            want.status = lzc_pkg::STATUS_OVF;
          end else if (run_len < 2) begin
            want.status = lzc_pkg::STATUS_SHORT;
          end else begin
            want.status = lzc_pkg::STATUS_OK;
            cx = lz76_phrase_count(run_len);
            if (cx > CX_MAX) cx = CX_MAX;
            want.complexity = cx[lzc_pkg::CX_W-1:0];
          end
          due_results.push_back(want);
          run_len = 0;
          run_overflowed = 1'b0;
        end
      end

      // result word against the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        got.complexity = out_mon.complexity;
        got.status = out_mon.status;
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result word complexity=%0d status=%0d",
                     $realtime, got.complexity, got.status);
        end else begin
          want = due_results.pop_front();
          if (got.complexity !== want.complexity || got.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: result mismatch: expected complexity=%0d status=%0d,",
                        " got complexity=%0d status=%0d"},
                       $realtime, want.complexity, want.status,
                       got.complexity, got.status);
          end
        end
      end
    end
    results_due <= due_results.size();
  end

endmodule

/* test/lempel_ziv_complexity_engine_tb.sv */
`timescale 1ns / 100ps
module lempel_ziv_complexity_engine_tb;

  localparam int LONG_HOLD       = 400;
  localparam int RANDOM_PHASES   = 5;
  localparam int WORDS_PER_PHASE = 120;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_we;
  logic [lzc_pkg::MEAN_W-1:0] cfg_wdata;
  logic [lzc_pkg::MEAN_W-1:0] mean_now;
  int unsigned                hold_reqs;
  logic                       src_quiet;
  int unsigned                mismatches;
  int unsigned                results_due;

  lzc_in_if  in_ch ();
  lzc_out_if out_ch ();

  lempel_ziv_complexity_engine DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  lz_complexity_checker lz_watch (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .mismatches  (mismatches),
    .results_due (results_due)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #(20_000_000);
    $display("lempel_ziv_complexity_engine_tb: FAIL");
    $finish;
  end

  // intervals mostly near the mean so both symbols turn up, some anywhere
  function automatic logic [lzc_pkg::IVL_W-1:0] pick_interval(
    input logic [lzc_pkg::MEAN_W-1:0] m);
    int centre, span, v;
    centre = m >> 4;
    span = centre * 3 / 10 + 2;
    if ($urandom_range(0, 3) == 0) v = $urandom_range(0, 4095);
    else v = centre - span + $urandom_range(0, 2 * span);
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[lzc_pkg::IVL_W-1:0];
  endfunction

  // one interval word, called and returning at a falling edge
  task automatic send_interval(input logic [lzc_pkg::IVL_W-1:0] ivl, input logic lst);
    int gap;
    gap = src_quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.interval <= ivl;
    in_ch.last <= lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if ($urandom_range(0, 19) == 0) src_quiet = !src_quiet;
    @(negedge clk);
  endtask

  task automatic send_beat_run(input int unsigned len);
    int unsigned j;
    for (j = 0; j < len; j++) send_interval(pick_interval(mean_now), j == len - 1);
  endtask

  // mean write only once the block has gone quiet
  task automatic load_mean(input logic [lzc_pkg::MEAN_W-1:0] m);
    in_ch.valid <= 1'b0;
    wait (results_due == 0);
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    mean_now = m;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // result side: random stalls per word, calm stretches, long hold on request
  initial begin : result_sink
    int          gap, hold;
    int unsigned hold_served;
    logic        took, calm;
    out_ch.ready = 1'b0;
    gap = 0;
    hold = 0;
    hold_served = 0;
    calm = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      took = out_ch.valid && out_ch.ready;
      if (hold_reqs != hold_served) begin
        hold_served = hold_reqs;
        hold = LONG_HOLD;
      end
      if (took) begin
        if ($urandom_range(0, 19) == 0) calm = !calm;
        gap = calm ? 0 : $urandom_range(0, 6);
      end
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int unsigned sent, len;
    int          p, m_pick;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.interval = '0;
    in_ch.last = 1'b0;
    hold_reqs = 0;
    src_quiet = 1'b0;
    mean_now = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // zero mean: only a zero interval gives a 0 symbol; single-word run is too short
    load_mean(16'd0);
    send_interval(12'd0, 1'b1);
    send_interval(12'd0, 1'b0);
    send_interval(12'hFFF, 1'b1);
    send_interval(12'd1, 1'b0);
    send_interval(12'd0, 1'b0);
    send_interval(12'd0, 1'b1);

    // mean 1000: both sides of the 15 percent threshold
    load_mean(16'd16000);
    send_interval(12'd1000, 1'b0);
    send_interval(12'd1150, 1'b0);
    send_interval(12'd1151, 1'b0);
    send_interval(12'd850, 1'b0);
    send_interval(12'd849, 1'b0);
    send_interval(12'hFFF, 1'b0);
    send_interval(12'd0, 1'b1);
    send_interval(12'd1000, 1'b1);

    // largest mean
    load_mean(16'hFFFF);
    send_interval(12'hFFF, 1'b0);
    send_interval(12'd0, 1'b0);
    send_interval(12'd3500, 1'b0);
    send_interval(12'd3480, 1'b1);

    // random runs, mostly short, under several means
    for (p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       m_pick = $urandom_range(100, 4000) * 16;
        1:       m_pick = $urandom_range(1, 65535);
        2:       m_pick = 1;
        3:       m_pick = 65535;
        default: m_pick = $urandom_range(20, 300) * 16;
      endcase
      load_mean(m_pick[lzc_pkg::MEAN_W-1:0]);
      // receiver holds off while short runs keep coming, so the queue fills
      if (p == 1 || p == 3) hold_reqs++;
      sent = 0;
      while (sent < WORDS_PER_PHASE) begin
        case ($urandom_range(0, 15))
          0:       len = 1;
          1:       len = $urandom_range(60, 200);
          default: len = $urandom_range(2, 24);
        endcase
        send_beat_run(len);
        sent += len;
      end
    end

    in_ch.valid <= 1'b0;
    wait (results_due == 0);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && results_due == 0) begin
      $display("lempel_ziv_complexity_engine_tb: PASS");
    end else begin
      $display("lempel_ziv_complexity_engine_tb: FAIL");
    end
    $finish;
  end

endmodule
